// ===== src/k_differences_text_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// k-differences text scanner assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef K_DIFFERENCES_TEXT_SCANNER_MACROS_SVH
`define K_DIFFERENCES_TEXT_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define KDTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kdts check failed");
// Next-cycle implication, checked outside reset.
`define KDTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kdts check failed");
`else
`define KDTS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KDTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/kdts_pkg.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner package
// Field widths, command and register codes, and the token passed along cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kdts_pkg;

  localparam int SYM_W  = 8;
  localparam int IDX_W  = 7;
  localparam int POS_W  = 24;
  localparam int CFG_W  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] PATTERN_LENGTH_RESET = 8'd1;
  localparam logic [CFG_W-1:0] MAX_ERRORS_RESET     = 8'd0;
  localparam logic [CFG_W-1:0] DISTANCE_SAT         = 8'hFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } kdts_cmd_t;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_MAX_ERRORS     = 1'b1
  } kdts_reg_t;

  // One request as it travels down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             scan;
    logic             start;
    logic [IDX_W-1:0] idx;
    logic [SYM_W-1:0] sym;
  } kdts_tok_t;

  typedef struct packed {
    logic [CFG_W-1:0] pattern_length;
    logic [CFG_W-1:0] max_errors;
  } kdts_cfg_t;

endpackage

`default_nettype wire

// ===== src/kdts_in_if.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner input channel
// Valid/ready channel carrying load and scan requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdts_in_if import kdts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] pattern_index;
  logic [SYM_W-1:0] symbol;
  logic             text_start;

  modport source (output valid, output cmd, output pattern_index, output symbol,
                  output text_start, input ready);
  modport sink   (input valid, input cmd, input pattern_index, input symbol,
                  input text_start, output ready);
endinterface

`default_nettype wire

// ===== src/kdts_out_if.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner result channel
// Valid/ready channel carrying one result per scanned character.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdts_out_if import kdts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] end_position;
  logic [CFG_W-1:0] distance;
  logic             within_limit;

  modport source (output valid, output end_position, output distance,
                  output within_limit, input ready);
  modport sink   (input valid, input end_position, input distance,
                  input within_limit, output ready);
endinterface

`default_nettype wire

// ===== src/kdts_regs.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner configuration registers
// APB-style register file holding pattern length and error limit.
// ----------------------------------------------------------------------------
`default_nettype none

module kdts_regs import kdts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output kdts_cfg_t              cfg
);

  kdts_reg_t reg_sel;
  logic      wr_en;

  // Registers sit one word apart, so bit 2 picks the register.
  assign reg_sel = kdts_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= PATTERN_LENGTH_RESET;
      cfg.max_errors     <= MAX_ERRORS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[CFG_W-1:0];
        REG_MAX_ERRORS:     cfg.max_errors     <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  // Read-back.
  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.pattern_length};
      REG_MAX_ERRORS:     prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.max_errors};
    endcase
  end

endmodule

`default_nettype wire

// ===== src/kdts_cell.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner cell
// One pattern row: holds its pattern character and edit distance, and
// updates the distance as each scanned character passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module kdts_cell import kdts_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  parameter int ROW         = 1,
  localparam int DIST_W     = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [DIST_W-1:0] m_sel,
  input  wire kdts_tok_t         tok_in,
  input  wire logic [DIST_W-1:0] new_in,
  input  wire logic [DIST_W-1:0] old_in,
  input  wire logic [DIST_W-1:0] res_in,
  output kdts_tok_t              tok_out,
  output logic      [DIST_W-1:0] new_out,
  output logic      [DIST_W-1:0] old_out,
  output logic      [DIST_W-1:0] res_out
);

  localparam logic [DIST_W-1:0] ROW_D = DIST_W'(ROW);
  localparam int                IDX   = ROW - 1;

  logic [SYM_W-1:0]  pat;
  logic [DIST_W-1:0] row_dist;
  logic [DIST_W-1:0] left;
  logic [DIST_W-1:0] upd;
  logic [DIST_W:0]   c_diag, c_up, c_left, best;
  logic              cost;
  logic              load_hit;
  logic              scan_go;

  // A text start clears the column to its reset value before this character.
  assign left     = tok_in.start ? ROW_D : row_dist;
  assign cost     = (pat != tok_in.sym);
  assign load_hit = tok_in.valid && !tok_in.scan && (32'(tok_in.idx) == IDX);
  assign scan_go  = tok_in.valid && tok_in.scan;

  // Edit-distance recurrence: diagonal, from the row above, and from the left.
  always_comb begin
    c_diag = {1'b0, old_in} + (DIST_W+1)'(cost);
    c_up   = {1'b0, new_in} + (DIST_W+1)'(1);
    c_left = {1'b0, left}   + (DIST_W+1)'(1);
    best   = (c_diag < c_up) ? c_diag : c_up;
    if (c_left < best) begin
      best = c_left;
    end
    upd = best[DIST_W-1:0];
  end

  // Pattern character, written when a load for this row passes.
  always_ff @(posedge clk) begin
    if (adv && load_hit) begin
      pat <= tok_in.sym;
    end
  end

  // Own column entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_dist <= ROW_D;
    end else if (adv && scan_go) begin
      row_dist <= upd;
    end
  end

  // Hand the request and the row values on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_out <= upd;
      old_out <= left;
      res_out <= (m_sel == ROW_D) ? upd : res_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/kdts_result.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner result stage
// Output register, text position counter and the match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kdts_result import kdts_pkg::*; #(
  parameter int MAX_PATTERN = 128,
  localparam int DIST_W     = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kdts_tok_t         tok_last,
  input  wire logic [DIST_W-1:0] res_last,
  input  wire logic [CFG_W-1:0]  max_errors,
  output logic                   adv,
  kdts_out_if.source             result_out
);

  logic [POS_W-1:0] pos_cnt;
  logic [POS_W-1:0] pos;
  logic [CFG_W-1:0] dist_sat;
  logic             emit;

  // The chain moves whenever the output register is free or being emptied.
  assign adv  = !result_out.valid || result_out.ready;
  assign emit = tok_last.valid && tok_last.scan;
  assign pos  = tok_last.start ? '0 : pos_cnt;

  always_comb begin
    if (32'(res_last) > 32'(DISTANCE_SAT)) begin
      dist_sat = DISTANCE_SAT;
    end else begin
      dist_sat = CFG_W'(res_last);
    end
  end

  // Text position of the next scanned character.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
    end else if (adv && emit) begin
      pos_cnt <= pos + POS_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (adv) begin
      result_out.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      result_out.end_position <= pos;
      result_out.distance     <= dist_sat;
      result_out.within_limit <= (dist_sat <= max_errors);
    end
  end

endmodule

`default_nettype wire

// ===== src/k_differences_text_scanner.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner
// Approximate pattern search with at most k edit differences, matches
// starting anywhere in the text, built as a systolic row of cells.
// ----------------------------------------------------------------------------
// Each request enters a chain of MAX_PATTERN cells, one cell per pattern
// row, and moves one cell per cycle; a new request is taken every cycle
// while the result register is free or being emptied. Load requests write
// the pattern character of their row as they pass and give no result. A
// scan request gives one result once it has passed the chain and then the
// output register; the cell of row pattern_length, clamped to the rows that
// exist, drops its distance onto a result lane that runs to the end of the
// chain. When a result is not taken the whole chain holds. The column is
// cleared by reset at once, so no start-up sweep is needed; pattern
// characters are undefined until loaded.
`default_nettype none
`include "k_differences_text_scanner_macros.svh"

module k_differences_text_scanner import kdts_pkg::*; #(
  parameter int MAX_PATTERN = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  kdts_in_if.sink                scan_in,
  kdts_out_if.source             result_out
);

  localparam int DIST_W = $clog2(MAX_PATTERN + 1);

  kdts_cfg_t         cfg;
  logic              adv;
  logic [DIST_W-1:0] m_sel;

  kdts_tok_t         tok      [0:MAX_PATTERN];
  logic [DIST_W-1:0] new_lane [0:MAX_PATTERN];
  logic [DIST_W-1:0] old_lane [0:MAX_PATTERN];
  logic [DIST_W-1:0] res_lane [0:MAX_PATTERN];

  // Configuration registers.
  kdts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pattern length limited to the rows that exist.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      m_sel = DIST_W'(1);
    end else if (32'(cfg.pattern_length) > MAX_PATTERN) begin
      m_sel = DIST_W'(MAX_PATTERN);
    end else begin
      m_sel = DIST_W'(cfg.pattern_length);
    end
  end

  // Head of the chain: row zero is always zero.
  assign scan_in.ready = adv;
  assign tok[0].valid  = scan_in.valid;
  assign tok[0].scan   = (scan_in.cmd == CMD_SCAN);
  assign tok[0].start  = scan_in.text_start;
  assign tok[0].idx    = scan_in.pattern_index;
  assign tok[0].sym    = scan_in.symbol;
  assign new_lane[0]   = '0;
  assign old_lane[0]   = '0;
  assign res_lane[0]   = '0;

  // Row of cells.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    kdts_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .ROW         (g + 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .m_sel   (m_sel),
      .tok_in  (tok[g]),
      .new_in  (new_lane[g]),
      .old_in  (old_lane[g]),
      .res_in  (res_lane[g]),
      .tok_out (tok[g+1]),
      .new_out (new_lane[g+1]),
      .old_out (old_lane[g+1]),
      .res_out (res_lane[g+1])
    );
  end

  // Result register and position counter.
  kdts_result #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .tok_last   (tok[MAX_PATTERN]),
    .res_last   (res_lane[MAX_PATTERN]),
    .max_errors (cfg.max_errors),
    .adv        (adv),
    .result_out (result_out)
  );

  // A waiting result blocks new requests.
  `KDTS_ASSERT_IMPLY(a_stall_blocks_input, clk, rst,
    result_out.valid && !result_out.ready, !scan_in.ready)
  // A held chain keeps the request at its end.
  `KDTS_ASSERT_NEXT(a_chain_holds, clk, rst, !adv, $stable(tok[MAX_PATTERN]))
  // An accepted request reaches the first cell.
  `KDTS_ASSERT_NEXT(a_request_enters, clk, rst,
    scan_in.valid && scan_in.ready, tok[1].valid)

endmodule

`default_nettype wire

// ===== bench/k_differences_text_scanner_checker.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner checker
// Watches the register port and both channels, keeps its own copy of the
// pattern, the edit-distance column and the text position, predicts one
// result per scan request and compares every accepted result with the
// oldest prediction.
// ----------------------------------------------------------------------------

module k_differences_text_scanner_checker import kdts_pkg::*; #(
  parameter int MAX_PATTERN = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  kdts_in_if                scan_in,
  kdts_out_if               result_out,
  output int                failures,
  output int                outstanding
);

  typedef struct packed {
    logic [POS_W-1:0] end_position;
    logic [CFG_W-1:0] distance;
    logic             within_limit;
  } match_report_t;

  logic [SYM_W-1:0] pattern_copy [MAX_PATTERN];
  int               edit_column [MAX_PATTERN+1];
  logic [POS_W-1:0] char_position;
  logic [CFG_W-1:0] length_reg;
  logic [CFG_W-1:0] limit_reg;
  match_report_t    awaited [$];
  int               fault_count = 0;
  int               result_count = 0;

  assign failures = fault_count;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
             $time, what, result_count, got, want);
    fault_count++;
  endtask

  // Row 0 stays zero so that a match may begin anywhere; row i starts at i.
  task automatic clear_column();
    int i;
    for (i = 0; i <= MAX_PATTERN; i++) edit_column[i] = i;
  endtask

  // Advance the column by one text character and work out its result.
  task automatic score_character(input logic [SYM_W-1:0] ch, input logic restart,
                                 output match_report_t r);
    int i;
    int diag;
    int above;
    int keep;
    int best;
    int rows;
    if (restart) begin
      clear_column();
      char_position = '0;
    end
    diag = edit_column[0];
    for (i = 1; i <= MAX_PATTERN; i++) begin
      keep  = edit_column[i];
      above = edit_column[i-1];
      best  = diag + ((pattern_copy[i-1] != ch) ? 1 : 0);
      if (above + 1 < best) best = above + 1;
      if (keep + 1 < best) best = keep + 1;
      edit_column[i] = best;
      diag = keep;
    end
    // Out-of-range lengths are clamped to the rows that exist.
    if (length_reg == 0) rows = 1;
    else if (int'(length_reg) > MAX_PATTERN) rows = MAX_PATTERN;
    else rows = int'(length_reg);
    best = (edit_column[rows] > 255) ? 255 : edit_column[rows];
    r.end_position = char_position;
    r.distance     = CFG_W'(best);
    r.within_limit = (CFG_W'(best) <= limit_reg);
    char_position  = char_position + POS_W'(1);
  endtask

  // Track configuration, compare results, then predict for new requests.
  always @(posedge clk) begin : track
    match_report_t predicted;
    match_report_t want;
    int i;
    if (rst) begin
      for (i = 0; i < MAX_PATTERN; i++) pattern_copy[i] = '0;
      clear_column();
      char_position = '0;
      length_reg    = PATTERN_LENGTH_RESET;
      limit_reg     = MAX_ERRORS_RESET;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (kdts_reg_t'(paddr[ADDR_W-1:2]))
          REG_PATTERN_LENGTH: begin
            length_reg = pwdata[CFG_W-1:0];
          end
          REG_MAX_ERRORS: begin
            limit_reg = pwdata[CFG_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (result_out.valid && result_out.ready) begin
        result_count++;
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result, end_position", result_out.end_position, -1);
        end else begin
          want = awaited.pop_front();
          if (result_out.end_position !== want.end_position)
            report_mismatch("end_position", result_out.end_position, want.end_position);
          if (result_out.distance !== want.distance)
            report_mismatch("distance", result_out.distance, want.distance);
          if (result_out.within_limit !== want.within_limit)
            report_mismatch("within_limit", result_out.within_limit, want.within_limit);
        end
      end

      if (scan_in.valid && scan_in.ready) begin
        if (kdts_cmd_t'(scan_in.cmd) == CMD_LOAD) begin
          pattern_copy[scan_in.pattern_index] = scan_in.symbol;
        end else begin
          score_character(scan_in.symbol, scan_in.text_start, predicted);
          awaited.push_back(predicted);
        end
      end
    end
    outstanding <= awaited.size();
  end

endmodule

// ===== bench/k_differences_text_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// k-differences text scanner testbench
// Loads a pattern, then streams texts built from edited copies of it and
// from noise through the scanner under several register settings, with
// random gaps on the request side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module k_differences_text_scanner_tb;
  import kdts_pkg::*;

  localparam int MAX_PATTERN   = 128;
  localparam int SETTLE_CYCLES = MAX_PATTERN + 1 + 16;
  localparam int RANDOM_ITEMS  = 1580;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                failures;
  int                outstanding;

  kdts_in_if  scan_in ();
  kdts_out_if result_out ();

  // Stimulus-side view of the pattern, used to build near-matching texts.
  logic [SYM_W-1:0] pattern_mirror [MAX_PATTERN];
  int               alph_base;
  int               alph_size;
  bit               src_idle;
  bit               sink_stall;

  k_differences_text_scanner #(.MAX_PATTERN(MAX_PATTERN)) dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .scan_in    (scan_in),
    .result_out (result_out)
  );

  k_differences_text_scanner_checker #(.MAX_PATTERN(MAX_PATTERN)) result_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .scan_in     (scan_in),
    .result_out  (result_out),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, well above the slowest correct run.
  initial begin
    #4000000;
    $display("k_differences_text_scanner regression: fail");
    $finish;
  end

  // A character from the current alphabet; narrow alphabets give close matches.
  function automatic logic [SYM_W-1:0] pick_symbol();
    return SYM_W'(alph_base + $urandom_range(0, alph_size - 1));
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(input kdts_cmd_t cmd, input logic [IDX_W-1:0] idx,
                              input logic [SYM_W-1:0] sym, input logic start);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      scan_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_in.valid         = 1'b1;
    scan_in.cmd           = cmd;
    scan_in.pattern_index = idx;
    scan_in.symbol        = sym;
    scan_in.text_start    = start;
    if (cmd == CMD_LOAD) pattern_mirror[idx] = sym;
    @(posedge clk);
    while (!scan_in.ready) @(posedge clk);
  endtask

  // Stop offering requests and wait for every result; optionally let the
  // chain empty of loads as well.
  task automatic settle(input bit full);
    @(negedge clk);
    scan_in.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    if (full) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input kdts_reg_t which, input logic [CFG_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] k);
    settle(1'b1);
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_MAX_ERRORS, k);
  endtask

  // Result side: a random stall before each result, or none in quiet phases.
  initial begin
    int stall;
    result_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = sink_stall ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        result_out.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_out.ready = 1'b1;
      @(posedge clk);
      while (!(result_out.valid && result_out.ready)) @(posedge clk);
    end
  end

  // Request side: directed opening, then random phases.
  initial begin : stimulus
    int i;
    int n;
    int eff_m;
    int text_len;
    int copy_at;
    int pause_at;
    int edit;
    int random_count;
    bit fresh;
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] k;
    logic [SYM_W-1:0] sym;

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    scan_in.valid         = 1'b0;
    scan_in.cmd           = CMD_SCAN;
    scan_in.pattern_index = '0;
    scan_in.symbol        = '0;
    scan_in.text_start    = 1'b0;
    src_idle              = 1'b1;
    sink_stall            = 1'b1;
    alph_base             = 8'h61;
    alph_size             = 3;
    random_count          = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Every row takes part in each scan, so the whole store is written
    // first; text_start on a load must be ignored.
    for (i = 0; i < MAX_PATTERN; i++) begin
      if (i == 0) sym = 8'h00;
      else if (i == MAX_PATTERN - 1) sym = 8'hFF;
      else sym = 8'h61 + SYM_W'(i % 3);
      send_request(CMD_LOAD, IDX_W'(i), sym, i[0]);
    end

    // Short pattern: exact match, substitution, deletion, extreme symbols.
    configure(8'd3, 8'd1);
    send_request(CMD_SCAN, '0, 8'h00, 1'b1);
    send_request(CMD_SCAN, '0, 8'h62, 1'b0);
    send_request(CMD_SCAN, '0, 8'h63, 1'b0);
    send_request(CMD_SCAN, '0, 8'hFF, 1'b0);
    send_request(CMD_SCAN, '0, 8'h00, 1'b0);
    send_request(CMD_SCAN, '0, 8'h63, 1'b0);
    send_request(CMD_LOAD, 7'd127, 8'h00, 1'b1);
    send_request(CMD_SCAN, '0, 8'h62, 1'b0);

    // Longest pattern and widest limit, continuing the same text.
    configure(8'd128, 8'd128);
    send_request(CMD_SCAN, '0, 8'h61, 1'b0);
    send_request(CMD_SCAN, '0, 8'h62, 1'b0);
    send_request(CMD_SCAN, '0, 8'h00, 1'b0);

    // A length of zero acts as one; an oversize limit flags everything.
    configure(8'd0, 8'd255);
    send_request(CMD_SCAN, '0, 8'h00, 1'b1);
    send_request(CMD_SCAN, '0, 8'hFF, 1'b0);

    // An oversize length acts as the longest pattern; zero tolerance.
    configure(8'd255, 8'd0);
    send_request(CMD_SCAN, '0, 8'h00, 1'b1);
    send_request(CMD_SCAN, '0, 8'h62, 1'b0);
    send_request(CMD_SCAN, '0, 8'h63, 1'b1);

    // Random phases: a setting, maybe a fresh pattern, then a text made of
    // edited copies of the pattern mixed with noise.
    while (random_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 8'd0;
        1:       len = 8'd128;
        2:       len = CFG_W'($urandom_range(129, 255));
        3:       len = 8'd1;
        default: len = CFG_W'($urandom_range(2, 12));
      endcase
      if (len == 0) eff_m = 1;
      else if (len > MAX_PATTERN) eff_m = MAX_PATTERN;
      else eff_m = len;
      if ($urandom_range(0, 4) == 0) k = CFG_W'($urandom_range(0, 255));
      else k = CFG_W'($urandom_range(0, eff_m / 2 + 1));

      case ($urandom_range(0, 2))
        0:       alph_size = 2;
        1:       alph_size = 4;
        default: alph_size = 256;
      endcase
      alph_base = $urandom_range(0, 256 - alph_size);

      if ($urandom_range(0, 3) != 0) configure(len, k);
      src_idle   = ($urandom_range(0, 2) != 0);
      sink_stall = ($urandom_range(0, 2) != 0);

      if ($urandom_range(0, 3) != 0) begin
        for (i = 0; i < eff_m; i++) begin
          send_request(CMD_LOAD, IDX_W'(i), pick_symbol(), 1'($urandom_range(0, 1)));
          random_count++;
        end
      end

      text_len = (eff_m > 12) ? eff_m + $urandom_range(10, 40) : $urandom_range(15, 40);
      fresh    = ($urandom_range(0, 3) != 0);
      copy_at  = -1;
      pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, text_len - 1) : -1;
      for (n = 0; n < text_len; n++) begin
        // Now and then the sender holds off until every result is back.
        if (n == pause_at) settle(1'b0);
        if ($urandom_range(0, 19) == 0) begin
          send_request(CMD_LOAD, IDX_W'($urandom_range(0, MAX_PATTERN - 1)), pick_symbol(),
                       1'($urandom_range(0, 1)));
          random_count++;
        end
        if (copy_at < 0 && $urandom_range(0, 3) == 0) copy_at = 0;
        if (copy_at >= 0) begin
          // Copy the pattern with an occasional substitution, deletion or insertion.
          edit = $urandom_range(0, 15);
          if (edit == 1 && copy_at + 1 < eff_m) copy_at++;
          if (edit == 0 || edit == 2) sym = pick_symbol();
          else sym = pattern_mirror[copy_at];
          if (edit != 2) copy_at++;
          if (copy_at >= eff_m) copy_at = -1;
        end else if ($urandom_range(0, 7) == 0) begin
          sym = SYM_W'($urandom_range(0, 255));
        end else begin
          sym = pick_symbol();
        end
        send_request(CMD_SCAN, IDX_W'($urandom_range(0, MAX_PATTERN - 1)), sym,
                     (n == 0 && fresh) || ($urandom_range(0, 63) == 0));
        random_count++;
      end
    end

    settle(1'b1);
    if (failures == 0) begin
      $display("k_differences_text_scanner regression: pass");
    end else begin
      $display("k_differences_text_scanner regression: fail");
    end
    $finish;
  end

endmodule
